// ===== rtl/hfpu8_pkg.sv =====
// ----------------------------------------------------------------------------
// hfpu8_pkg
// Shared widths and binary16 field constants for the half-float to
// unorm8 pixel converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hfpu8_pkg;

  // binary16 layout
  localparam int HalfW  = 16;
  localparam int ExpW   = 5;
  localparam int ManW   = 10;
  localparam int ByteW  = 8;

  localparam logic [ExpW-1:0] ExpAllOnes = 5'h1F;
  localparam logic [ExpW-1:0] ExpZero    = 5'h00;
  // Exponent at which the magnitude reaches 1.0 or more
  localparam logic [ExpW-1:0] ExpOne     = 5'd15;

  // Magnitude in units of 2^-24; values below 1.0 fit in 24 bits
  localparam int MagW = 24;

  localparam logic [ByteW-1:0] ByteMax = 8'd255;
  localparam logic [ByteW-1:0] ByteMin = 8'd0;

  // Configuration register map (register index, taken from paddr[2])
  localparam int CfgAddrW = 3;
  localparam logic RegRemapSigned = 1'b0;

  // Pixel payload held in the input stage
  typedef struct packed {
    logic [HalfW-1:0] red;
    logic [HalfW-1:0] green;
    logic [HalfW-1:0] blue;
    logic [HalfW-1:0] alpha;
    logic             last;
  } pixel_t;

endpackage

// ===== rtl/half_float_pixel_to_unorm8.sv =====
// ----------------------------------------------------------------------------
// half_float_pixel_to_unorm8
// RGBA binary16 pixel to four unorm8 bytes, with optional signed remap.
// ----------------------------------------------------------------------------
// Accepts one pixel request per clock while the result is not stalled:
// the request lands in an input register, four single-pass channel
// converters work on it, and the bytes are caught in a result register.
// Both registers advance together, so a stalled result holds the input
// register and backpressure reaches in_ready in the same cycle. Writes to
// remap_signed (register 0, byte address 0) must be made while no pixel
// is in flight. In remap mode a pixel whose raw R, G and B words are all
// zero is treated as background and converts plainly, alpha included.
`timescale 1ns / 1ps

module half_float_pixel_to_unorm8
  import hfpu8_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // pixel requests
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [HalfW-1:0]    in_red_half,
  input  logic [HalfW-1:0]    in_green_half,
  input  logic [HalfW-1:0]    in_blue_half,
  input  logic [HalfW-1:0]    in_alpha_half,
  input  logic                in_last_pixel,
  // converted bytes
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ByteW-1:0]    out_red_byte,
  output logic [ByteW-1:0]    out_green_byte,
  output logic [ByteW-1:0]    out_blue_byte,
  output logic [ByteW-1:0]    out_alpha_byte,
  output logic                out_last_pixel_out,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic             remap_r;
  logic             s1_valid_r;
  pixel_t           s1_pix_r;
  logic             out_valid_r;
  logic [ByteW-1:0] red_r, green_r, blue_r, alpha_r;
  logic             last_r;

  logic             out_load;
  logic             s1_load;
  logic             background;
  logic             shift;
  logic [ByteW-1:0] red_nxt, green_nxt, blue_nxt, alpha_conv;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'b0, remap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remap_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr[2] == RegRemapSigned) begin
      remap_r <= cfg_pwdata[0];
    end
  end

  // Advance both stages together whenever the result register is free
  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_load;
  assign s1_load  = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pix_r <= '{red: in_red_half, green: in_green_half, blue: in_blue_half,
                    alpha: in_alpha_half, last: in_last_pixel};
    end
  end

  // Detect background and pick the conversion mode
  assign background = (s1_pix_r.red == '0) && (s1_pix_r.green == '0)
                      && (s1_pix_r.blue == '0);
  assign shift      = remap_r && !background;

  hfpu8_chan u_red   (.half_i(s1_pix_r.red),   .remap_i(shift), .byte_o(red_nxt));
  hfpu8_chan u_green (.half_i(s1_pix_r.green), .remap_i(shift), .byte_o(green_nxt));
  hfpu8_chan u_blue  (.half_i(s1_pix_r.blue),  .remap_i(shift), .byte_o(blue_nxt));
  hfpu8_chan u_alpha (.half_i(s1_pix_r.alpha), .remap_i(1'b0),  .byte_o(alpha_conv));

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= shift ? ByteMax : alpha_conv;
      last_r  <= s1_pix_r.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red_byte       = red_r;
  assign out_green_byte     = green_r;
  assign out_blue_byte      = blue_r;
  assign out_alpha_byte     = alpha_r;
  assign out_last_pixel_out = last_r;

  // Checks
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_load |=> s1_valid_r && $stable(s1_pix_r))
    else $error("input stage lost a waiting pixel");

  a_alpha_forced: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && remap_r && !background |=> out_alpha_byte == ByteMax)
    else $error("remapped pixel without opaque alpha");

  a_nan_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && s1_pix_r.red[14:10] == ExpAllOnes && s1_pix_r.red[9:0] != '0
    |=> out_red_byte == ByteMin)
    else $error("NaN red channel did not convert to zero");

  a_result_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without an input pixel");

endmodule

// ===== rtl/hfpu8_chan.sv =====
// ----------------------------------------------------------------------------
// hfpu8_chan
// Converts one binary16 channel to an unsigned normalized byte, either
// plainly (clamp to [0,1]) or after the signed remap (v+1)/2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfpu8_chan
  import hfpu8_pkg::*;
(
  input  logic [HalfW-1:0] half_i,
  input  logic             remap_i,
  output logic [ByteW-1:0] byte_o
);

  logic            neg;
  logic [ExpW-1:0] ex;
  logic [ManW-1:0] man;
  logic [3:0]      shamt;
  logic [MagW-1:0] mag;
  logic [MagW:0]   t_val;
  logic [31:0]     plain_sum;
  logic [32:0]     remap_sum;

  assign neg = half_i[HalfW-1];
  assign ex  = half_i[HalfW-2 -: ExpW];
  assign man = half_i[ManW-1:0];

  // Build the magnitude below 1.0; only used when ex is under ExpOne
  assign shamt = 4'(ex - 5'd1);
  always_comb begin
    if (ex == ExpZero) begin
      mag = MagW'(man);
    end else begin
      mag = MagW'({1'b1, man}) << shamt;
    end
  end

  // Plain: (255*mag + 2^23) >> 24, with 255*x as (x << 8) - x
  assign plain_sum = ({8'b0, mag} << 8) - {8'b0, mag} + 32'h0080_0000;

  // Remap: t = 1.0 +/- mag, then (255*t + 2^24) >> 25
  assign t_val = neg ? (25'h100_0000 - {1'b0, mag}) : (25'h100_0000 + {1'b0, mag});
  assign remap_sum = ({8'b0, t_val} << 8) - {8'b0, t_val} + 33'h0_0100_0000;

  // Select special cases, saturation and the rounded result
  always_comb begin
    if (ex == ExpAllOnes) begin
      byte_o = (man != '0 || neg) ? ByteMin : ByteMax;
    end else if (ex >= ExpOne) begin
      byte_o = neg ? ByteMin : ByteMax;
    end else if (remap_i) begin
      byte_o = remap_sum[32:25];
    end else if (neg) begin
      byte_o = ByteMin;
    end else begin
      byte_o = plain_sum[31:24];
    end
  end

endmodule

// ===== tb/sv/half_float_pixel_to_unorm8_test.sv =====
// ----------------------------------------------------------------------------
// half_float_pixel_to_unorm8_test
// Stream check of the binary16 RGBA to unorm8 pixel converter.
// ----------------------------------------------------------------------------
// A clocked driver presents pixel requests from a pending queue and, on each
// accepted request, computes the expected bytes with an exact fixed-point
// conversion of its own. A clocked monitor compares every returned pixel with
// the oldest expected one. The run covers directed corner values in plain
// and signed-remap mode, then random pixels under three idle patterns, a long
// receiver hold-off and register writes made between drained phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module half_float_pixel_to_unorm8_test;
  import hfpu8_pkg::*;

  localparam logic [CfgAddrW-1:0] RemapAddr  = 3'd0;
  localparam logic [CfgAddrW-1:0] UnusedAddr = 3'd4;
  localparam logic [63:0]         OneFix     = 64'h100_0000;
  localparam int                  HoldCycles = 400;
  localparam int                  PhaseItems = 200;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] alpha;
    logic             last;
  } unorm_pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [HalfW-1:0] in_red_half = '0;
  logic [HalfW-1:0] in_green_half = '0;
  logic [HalfW-1:0] in_blue_half = '0;
  logic [HalfW-1:0] in_alpha_half = '0;
  logic             in_last_pixel = 1'b0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ByteW-1:0] out_red_byte;
  logic [ByteW-1:0] out_green_byte;
  logic [ByteW-1:0] out_blue_byte;
  logic [ByteW-1:0] out_alpha_byte;
  logic             out_last_pixel_out;

  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  half_float_pixel_to_unorm8 dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_red_half        (in_red_half),
    .in_green_half      (in_green_half),
    .in_blue_half       (in_blue_half),
    .in_alpha_half      (in_alpha_half),
    .in_last_pixel      (in_last_pixel),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_red_byte       (out_red_byte),
    .out_green_byte     (out_green_byte),
    .out_blue_byte      (out_blue_byte),
    .out_alpha_byte     (out_alpha_byte),
    .out_last_pixel_out (out_last_pixel_out),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  // Testbench state
  pixel_t       pending_pixels[$];
  unorm_pixel_t expected_bytes[$];
  pixel_t       offered;
  pixel_t       next_px;
  unorm_pixel_t got_px;
  unorm_pixel_t want_px;
  logic         remap_mirror = 1'b0;
  int           tx_idle_pct = 26;
  int           rx_idle_pct = 83;
  int           accepted_count = 0;
  int           result_count = 0;
  int           error_count = 0;
  logic         hold_req = 1'b0;
  logic         hold_seen = 1'b0;
  int           hold_left = 0;

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Convert one binary16 pattern exactly; remap selects (v+1)/2 first
  function automatic logic [ByteW-1:0] half_to_unorm8(logic [HalfW-1:0] h, logic remap);
    logic            neg;
    logic [ExpW-1:0] ex;
    logic [ManW-1:0] man;
    logic [63:0]     mag;
    logic [63:0]     t;
    neg = h[15];
    ex  = h[14:10];
    man = h[ManW-1:0];
    if (ex == ExpAllOnes) begin
      return (man != '0 || neg) ? ByteMin : ByteMax;
    end
    mag = (ex == ExpZero) ? 64'(man) : (64'({1'b1, man}) << (ex - 5'd1));
    if (!remap) begin
      if (neg || mag == '0) return ByteMin;
      if (mag >= OneFix) return ByteMax;
      t = (64'd255 * mag + (OneFix >> 1)) >> 24;
      return t[ByteW-1:0];
    end
    // Shift into [0,2) in units of 2^-24, then scale by 255/2
    if (mag >= OneFix) return neg ? ByteMin : ByteMax;
    t = neg ? OneFix - mag : OneFix + mag;
    t = (64'd255 * t + OneFix) >> 25;
    return t[ByteW-1:0];
  endfunction

  // Expected bytes for one pixel under the current remap setting
  function automatic unorm_pixel_t convert_pixel(pixel_t px, logic remap);
    unorm_pixel_t res;
    logic         shift;
    shift = remap && !(px.red == '0 && px.green == '0 && px.blue == '0);
    res.red   = half_to_unorm8(px.red, shift);
    res.green = half_to_unorm8(px.green, shift);
    res.blue  = half_to_unorm8(px.blue, shift);
    res.alpha = shift ? ByteMax : half_to_unorm8(px.alpha, 1'b0);
    res.last  = px.last;
    return res;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Driver: offer the next pending request, hold it until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_bytes.push_back(convert_pixel(offered, remap_mirror));
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_px = pending_pixels.pop_front();
          offered       <= next_px;
          in_valid      <= 1'b1;
          in_red_half   <= next_px.red;
          in_green_half <= next_px.green;
          in_blue_half  <= next_px.blue;
          in_alpha_half <= next_px.alpha;
          in_last_pixel <= next_px.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: compare each returned pixel with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_px = '{out_red_byte, out_green_byte, out_blue_byte, out_alpha_byte,
                 out_last_pixel_out};
      if (expected_bytes.size() == 0) begin
        report_error($sformatf("pixel %0d returned with none pending", result_count));
      end else begin
        want_px = expected_bytes.pop_front();
        if (got_px !== want_px) begin
          report_error($sformatf(
            "pixel %0d: got r%0d g%0d b%0d a%0d l%0d, want r%0d g%0d b%0d a%0d l%0d",
            result_count, got_px.red, got_px.green, got_px.blue, got_px.alpha,
            got_px.last, want_px.red, want_px.green, want_px.blue, want_px.alpha,
            want_px.last));
        end
      end
      result_count++;
    end
  end

  // One APB transfer: setup, access, complete on pready
  task automatic cfg_access(logic wr, logic [CfgAddrW-1:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    if (wr && addr[2] == RegRemapSigned) remap_mirror = wdata[0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Wait until nothing is pending or in flight
  task automatic drain();
    while (pending_pixels.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write a register while idle, then read remap back
  task automatic write_cfg(logic [CfgAddrW-1:0] addr, logic [31:0] data);
    logic [31:0] rd;
    drain();
    cfg_access(1'b1, addr, data, rd);
    cfg_access(1'b0, RemapAddr, '0, rd);
    if (rd !== {31'b0, remap_mirror})
      report_error($sformatf("remap readback %0h, want %0h", rd, remap_mirror));
  endtask

  task automatic add_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic [15:0] a, logic last);
    pending_pixels.push_back('{r, g, b, a, last});
  endtask

  // Corner values: zero/background, one, max finite, subnormals, infinities,
  // NaNs, negative zero, midpoint and rounding neighbors
  task automatic load_directed();
    @(negedge clk);
    add_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_pixel(16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00, 1'b1);
    add_pixel(16'h7BFF, 16'hFBFF, 16'h0001, 16'h8001, 1'b0);
    add_pixel(16'h7C00, 16'hFC00, 16'h7E00, 16'hFC01, 1'b1);
    add_pixel(16'h8000, 16'h0000, 16'h0000, 16'h7C01, 1'b0);
    add_pixel(16'h0000, 16'h3800, 16'hB800, 16'h3800, 1'b0);
    add_pixel(16'hBC00, 16'h3BFF, 16'h3C01, 16'hBC00, 1'b1);
    add_pixel(16'h0000, 16'h0000, 16'h0000, 16'h7C00, 1'b1);
    add_pixel(16'hFFFF, 16'h7FFF, 16'h03FF, 16'h0400, 1'b0);
    add_pixel(16'h1C04, 16'h1C05, 16'h2000, 16'h2004, 1'b0);
    add_pixel(16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 1'b1);
    add_pixel(16'h5555, 16'hAAAA, 16'h3555, 16'hCAAA, 1'b0);
  endtask

  // Bias toward specials, subnormals and the region around 1.0
  function automatic logic [HalfW-1:0] random_half();
    logic [HalfW-1:0] h;
    case ($urandom_range(7))
      0: h = {1'($urandom_range(1)), ExpAllOnes,
              ($urandom_range(3) == 0) ? 10'h000 : 10'($urandom)};
      1: h = {1'($urandom_range(1)), 5'(13 + $urandom_range(2)), 10'($urandom)};
      2: h = {1'($urandom_range(1)), ExpZero, 10'($urandom)};
      default: h = 16'($urandom);
    endcase
    return h;
  endfunction

  task automatic load_random(int n, int tx_pct, int rx_pct);
    pixel_t px;
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) begin
      px.red   = random_half();
      px.green = random_half();
      px.blue  = random_half();
      px.alpha = random_half();
      px.last  = ($urandom_range(7) == 0);
      // Mix in background pixels
      if ($urandom_range(11) == 0) begin
        px.red   = '0;
        px.green = '0;
        px.blue  = '0;
      end
      pending_pixels.push_back(px);
    end
  endtask

  // Main sequence
  initial begin
    int mark;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels in plain and remap mode
    write_cfg(RemapAddr, 32'h0000_0000);
    load_directed();
    write_cfg(RemapAddr, 32'h0000_0001);
    load_directed();

    // Unknown index is ignored; only bit 0 of the data counts
    write_cfg(UnusedAddr, 32'hFFFF_FFFE);
    write_cfg(RemapAddr, 32'hFFFF_FFFE);

    // Sender idles lightly, receiver heavily
    load_random(PhaseItems, 26, 83);
    write_cfg(RemapAddr, 32'h0000_0001);
    load_random(PhaseItems, 26, 83);

    // Sender idles heavily, receiver lightly
    write_cfg(RemapAddr, 32'h0000_0000);
    load_random(PhaseItems, 83, 26);
    write_cfg(RemapAddr, 32'hFFFF_FFFF);
    load_random(PhaseItems, 83, 26);

    // No idling; hold off the receiver while the sender keeps offering
    write_cfg(RemapAddr, 32'h0000_0001);
    mark = accepted_count;
    load_random(PhaseItems, 0, 0);
    while (accepted_count < mark + 40) @(negedge clk);
    hold_req = ~hold_req;
    write_cfg(RemapAddr, 32'h0000_0000);
    load_random(PhaseItems, 0, 0);

    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("half_float_pixel_to_unorm8_test: clean");
    end else begin
      $display("half_float_pixel_to_unorm8_test: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("half_float_pixel_to_unorm8_test: errors");
    $finish;
  end

endmodule
